// ===== src/shmr_pkg.sv =====
`default_nettype none

package shmr_pkg;

	// Characters that steer the message router.
	localparam logic [7:0] CH_NUL          = 8'h00;
	localparam logic [7:0] CH_END          = 8'h3A;  // ':'
	localparam logic [7:0] CH_TO_UART      = 8'h75;  // 'u'
	localparam logic [7:0] CH_TO_CTRL      = 8'h6C;  // 'l'
	localparam logic [7:0] HEX_ALPHA_LIMIT = 8'h40;
	localparam logic [3:0] HEX_ALPHA_ADJ   = 4'd9;

	// Number of turnaround transfers ignored after a transmit burst ends.
	localparam logic [1:0] TURNAROUND_LEN  = 2'd2;

	// One completed SPI transfer.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       queue_has_byte;
		logic [7:0] queue_head;
	} shmr_item_t;

	// What one transfer causes.
	typedef struct packed {
		logic       reply_valid;
		logic [7:0] reply_byte;
		logic       queue_pop;
		logic       ctrl_push;
		logic [7:0] ctrl_byte;
		logic       uart_push;
		logic [7:0] uart_byte;
		logic       message_done;
	} shmr_result_t;

	// Router state carried from one transfer to the next.
	typedef struct packed {
		logic [1:0] idle_left;
		logic       sending;
		logic       second_char;
		logic       to_uart;
		logic [7:0] held_char;
	} shmr_state_t;

	// Hex character value. Letters above 0x40 get 9 added, which may carry
	// into a fifth bit; that bit is kept since it reaches the low nibble's OR.
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		logic [4:0] v;
		v = {1'b0, c[3:0]};
		if (c > HEX_ALPHA_LIMIT) begin
			v = v + {1'b0, HEX_ALPHA_ADJ};
		end
		return v;
	endfunction

	// Byte from a high and a low hex character, truncated to eight bits.
	function automatic logic [7:0] decode_pair(input logic [7:0] hi, input logic [7:0] lo);
		logic [4:0] nh;
		logic [4:0] nl;
		nh = nibble_of(hi);
		nl = nibble_of(lo);
		return {nh[3:0], 4'b0000} | {3'b000, nl};
	endfunction

endpackage

`default_nettype wire

// ===== src/shmr_if.sv =====
`default_nettype none

// Channel that carries one completed SPI transfer.
interface shmr_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       queue_has_byte;
	logic [7:0] queue_head;

	modport source (output valid, rx_byte, queue_has_byte, queue_head, input ready);
	modport sink   (input valid, rx_byte, queue_has_byte, queue_head, output ready);
endinterface

// Channel that carries the result word of one transfer.
interface shmr_result_if;
	logic       valid;
	logic       ready;
	logic       reply_valid;
	logic [7:0] reply_byte;
	logic       queue_pop;
	logic       ctrl_push;
	logic [7:0] ctrl_byte;
	logic       uart_push;
	logic [7:0] uart_byte;
	logic       message_done;

	modport source (output valid, reply_valid, reply_byte, queue_pop, ctrl_push, ctrl_byte,
		uart_push, uart_byte, message_done, input ready);
	modport sink   (input valid, reply_valid, reply_byte, queue_pop, ctrl_push, ctrl_byte,
		uart_push, uart_byte, message_done, output ready);
endinterface

`default_nettype wire

// ===== src/shmr_step.sv =====
`default_nettype none

// Next-state and result logic for one SPI transfer.
module shmr_step (
	input  shmr_pkg::shmr_state_t  cur,
	input  shmr_pkg::shmr_item_t   item,
	output shmr_pkg::shmr_state_t  nxt,
	output shmr_pkg::shmr_result_t res
);
	import shmr_pkg::*;

	always_comb begin
		nxt = cur;
		res = '0;
		if (cur.idle_left != 2'd0) begin
			// Turnaround transfer: count it down and do nothing else.
			nxt.idle_left = cur.idle_left - 2'd1;
		end else if (cur.sending) begin
			// Transmit mode: reply with the queue head, or end the burst.
			res.reply_valid = 1'b1;
			if (item.queue_has_byte) begin
				res.reply_byte = item.queue_head;
				res.queue_pop  = 1'b1;
			end else begin
				nxt.sending   = 1'b0;
				nxt.idle_left = TURNAROUND_LEN;
			end
		end else begin
			// Receive mode: reply 0x00 and sort the received byte.
			res.reply_valid = 1'b1;
			case (item.rx_byte)
				CH_NUL: begin
					nxt.sending     = 1'b1;
					nxt.second_char = 1'b0;
					nxt.to_uart     = 1'b0;
				end
				CH_END: begin
					if (cur.to_uart) begin
						nxt.to_uart = 1'b0;
					end else begin
						res.ctrl_push    = 1'b1;
						res.ctrl_byte    = item.rx_byte;
						res.message_done = 1'b1;
					end
				end
				CH_TO_UART: begin
					nxt.to_uart = 1'b1;
				end
				CH_TO_CTRL: begin
					nxt.to_uart = 1'b0;
				end
				default: begin
					if (cur.to_uart) begin
						if (cur.second_char) begin
							res.uart_push = 1'b1;
							res.uart_byte = decode_pair(cur.held_char, item.rx_byte);
						end else begin
							nxt.held_char = item.rx_byte;
						end
						nxt.second_char = ~cur.second_char;
					end else begin
						res.ctrl_push = 1'b1;
						res.ctrl_byte = item.rx_byte;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/spi_slave_hex_message_router_top.sv =====
`default_nettype none

// SPI slave message router. Each input word is one completed SPI byte
// transfer; each yields exactly one result word, in order. A transfer is
// registered, evaluated combinationally against the router state and the
// result held in an output register, so the block takes one transfer per
// clock cycle while the result register is not stalled; the router state
// updates with each evaluated transfer. A stalled result register holds the
// stage behind it, and the input stays ready while a waiting result is taken.
module spi_slave_hex_message_router_top (
	input  wire logic      clk,
	input  wire logic      arst_n,
	shmr_item_if.sink      item,
	shmr_result_if.source  result
);
	import shmr_pkg::*;

	logic         valid_s1;
	shmr_item_t   item_s1;
	logic         out_valid_q;
	shmr_result_t out_q;
	shmr_state_t  state_q;
	shmr_state_t  state_nxt;
	shmr_result_t res_nxt;
	logic         adv_s1;
	logic         take_in;

	// The evaluate stage moves on when the result register is free or drains.
	assign adv_s1     = !out_valid_q || result.ready;
	assign item.ready = !valid_s1 || adv_s1;
	assign take_in    = item.valid && item.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= '{rx_byte: item.rx_byte, queue_has_byte: item.queue_has_byte,
				queue_head: item.queue_head};
		end
	end

	shmr_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Router state advances once per evaluated transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			out_q <= res_nxt;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.reply_valid  = out_q.reply_valid;
	assign result.reply_byte   = out_q.reply_byte;
	assign result.queue_pop    = out_q.queue_pop;
	assign result.ctrl_push    = out_q.ctrl_push;
	assign result.ctrl_byte    = out_q.ctrl_byte;
	assign result.uart_push    = out_q.uart_push;
	assign result.uart_byte    = out_q.uart_byte;
	assign result.message_done = out_q.message_done;

endmodule

`default_nettype wire

// ===== verif/shmr_route_check.sv =====
`timescale 1ns / 100ps

// Watches both channels of the message router, predicts the result word of
// every accepted transfer and compares it with what the block delivers.
module shmr_route_check (
	input  logic   clk,
	input  logic   arst_n,
	shmr_item_if   item,
	shmr_result_if result,
	output int     mismatches,
	output int     outstanding,
	output int     outcomes_seen
);
	import shmr_pkg::*;

	// Router state as the predictor sees it.
	shmr_state_t  router;
	shmr_result_t predicted_outcomes[$];

	// Value of one hex character; letters may carry into bit four.
	function automatic logic [7:0] hex_weight(input logic [7:0] c);
		logic [7:0] v;
		v = {4'h0, c[3:0]};
		if (c > HEX_ALPHA_LIMIT) begin
			v = v + {4'h0, HEX_ALPHA_ADJ};
		end
		return v;
	endfunction

	// Applies one SPI transfer to the router state and returns what it causes.
	function automatic shmr_result_t route_transfer(input shmr_item_t t);
		shmr_result_t o;
		logic [7:0]   hi_w;
		logic [7:0]   lo_w;
		o = '0;

		// Turnaround transfers are swallowed whole.
		if (router.idle_left != 2'd0) begin
			router.idle_left = router.idle_left - 2'd1;
			return o;
		end

		o.reply_valid = 1'b1;

		// Transmit mode replies from the queue until it runs dry.
		if (router.sending) begin
			if (t.queue_has_byte) begin
				o.reply_byte = t.queue_head;
				o.queue_pop  = 1'b1;
			end else begin
				router.sending   = 1'b0;
				router.idle_left = TURNAROUND_LEN;
			end
			return o;
		end

		// Receive mode sorts the incoming character.
		case (t.rx_byte)
			CH_NUL: begin
				router.sending     = 1'b1;
				router.second_char = 1'b0;
				router.to_uart     = 1'b0;
			end
			CH_END: begin
				if (router.to_uart) begin
					router.to_uart = 1'b0;
				end else begin
					o.ctrl_push    = 1'b1;
					o.ctrl_byte    = t.rx_byte;
					o.message_done = 1'b1;
				end
			end
			CH_TO_UART: begin
				router.to_uart = 1'b1;
			end
			CH_TO_CTRL: begin
				router.to_uart = 1'b0;
			end
			default: begin
				if (router.to_uart) begin
					if (router.second_char) begin
						hi_w        = hex_weight(router.held_char);
						lo_w        = hex_weight(t.rx_byte);
						o.uart_push = 1'b1;
						o.uart_byte = {hi_w[3:0], 4'h0} | lo_w;
					end else begin
						router.held_char = t.rx_byte;
					end
					router.second_char = ~router.second_char;
				end else begin
					o.ctrl_push = 1'b1;
					o.ctrl_byte = t.rx_byte;
				end
			end
		endcase
		return o;
	endfunction

	// Results are checked before new transfers are predicted; with the input and
	// result registers in between, a word can never come back on the edge that accepts it.
	always @(posedge clk or negedge arst_n) begin : watch
		shmr_item_t   t;
		shmr_result_t got;
		shmr_result_t want;
		if (!arst_n) begin
			router = '0;
			predicted_outcomes.delete();
			mismatches    = 0;
			outcomes_seen = 0;
		end else begin
			if (result.valid && result.ready) begin
				got = {result.reply_valid, result.reply_byte, result.queue_pop,
					result.ctrl_push, result.ctrl_byte, result.uart_push,
					result.uart_byte, result.message_done};
				outcomes_seen++;
				if (predicted_outcomes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result word %0d arrived with nothing predicted", outcomes_seen);
					end
				end else begin
					want = predicted_outcomes.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result word %0d differs", outcomes_seen);
							$display("  expected reply %b/%h pop %b ctrl %b/%h uart %b/%h done %b",
								want.reply_valid, want.reply_byte, want.queue_pop,
								want.ctrl_push, want.ctrl_byte, want.uart_push,
								want.uart_byte, want.message_done);
							$display("  actual   reply %b/%h pop %b ctrl %b/%h uart %b/%h done %b",
								got.reply_valid, got.reply_byte, got.queue_pop,
								got.ctrl_push, got.ctrl_byte, got.uart_push,
								got.uart_byte, got.message_done);
						end
					end
				end
			end
			if (item.valid && item.ready) begin
				t = {item.rx_byte, item.queue_has_byte, item.queue_head};
				predicted_outcomes.push_back(route_transfer(t));
			end
		end
		outstanding = predicted_outcomes.size();
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import shmr_pkg::*;

	localparam int ITEM_TARGET = 1850;
	localparam int CALM_FROM   = 1200;
	localparam int CALM_TO     = 1450;
	localparam int PAUSE_AT    = 900;
	localparam int STALL_AT    = 500;
	localparam int STALL_LEN   = 200;
	localparam int STUCK_LIMIT = 1000;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   outcomes_seen;
	int   sent = 0;
	int   stuck_cycles = 0;

	shmr_item_if   item_ch ();
	shmr_result_if result_ch ();

	spi_slave_hex_message_router_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	shmr_route_check route_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item_ch),
		.result        (result_ch),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.outcomes_seen (outcomes_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offers one transfer word, with random gaps outside the calm stretch.
	task automatic send_transfer(input logic [7:0] rx, input logic has, input logic [7:0] head);
		while (!(sent >= CALM_FROM && sent < CALM_TO) && $urandom_range(0, 99) < 28) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid          <= 1'b1;
		item_ch.rx_byte        <= rx;
		item_ch.queue_has_byte <= has;
		item_ch.queue_head     <= head;
		do @(posedge clk); while (!item_ch.ready);
		sent++;
		@(negedge clk);
	endtask

	// Receive-mode transfer; the queue fields carry noise.
	task automatic send_rx(input logic [7:0] rx);
		send_transfer(rx, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
	endtask

	// Master polls: enter transmit, drain n queued bytes, hit the empty queue,
	// then clock through the two turnaround transfers.
	task automatic poll_burst(input int n);
		send_rx(CH_NUL);
		repeat (n) send_transfer(8'($urandom_range(0, 255)), 1'b1, 8'($urandom_range(0, 255)));
		send_transfer(8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)));
		repeat (2) send_rx(8'($urandom_range(0, 255)));
	endtask

	function automatic logic [7:0] random_hex_char();
		int v;
		v = $urandom_range(0, 21);
		if (v < 10) begin
			return 8'("0" + v);
		end else if (v < 16) begin
			return 8'("A" + v - 10);
		end
		return 8'("a" + v - 16);
	endfunction

	// Result side: random back-pressure, one long hold-off, and a calm stretch.
	initial begin : result_sink
		int stall_left;
		bit stalled_once;
		stall_left      = 0;
		stalled_once    = 1'b0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!stalled_once && outcomes_seen >= STALL_AT) begin
				stalled_once = 1'b1;
				stall_left   = STALL_LEN;
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (outcomes_seen >= CALM_FROM && outcomes_seen < CALM_TO) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= 28);
			end
		end
	end

	// Ends the run if no word moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
				if (stuck_cycles >= STUCK_LIMIT) begin
					$display("Test completed with failures");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		bit paused;
		paused                 = 1'b0;
		arst_n                 = 1'b0;
		item_ch.valid          = 1'b0;
		item_ch.rx_byte        = 8'h00;
		item_ch.queue_has_byte = 1'b0;
		item_ch.queue_head     = 8'h00;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Control bytes at both extremes and an end marker.
		send_rx(8'hFF);
		send_rx(8'h01);
		send_rx(CH_END);
		// Hex pairs: digits, both letter cases, the character just below the
		// letters, and an all-ones character whose value spills into bit four.
		send_rx(CH_TO_UART);
		send_rx("4");
		send_rx("1");
		send_rx("f");
		send_rx("F");
		send_rx("@");
		send_rx(8'hFF);
		// End marker while routed to the UART stores nothing.
		send_rx(CH_END);
		// A route switch in the middle of a pair keeps the held character.
		send_rx(CH_TO_UART);
		send_rx("7");
		send_rx(CH_TO_CTRL);
		send_rx(8'h55);
		send_rx(CH_TO_UART);
		send_rx("z");
		// Entering transmit clears a half-finished pair and the UART route.
		send_rx(CH_TO_UART);
		send_rx("3");
		send_rx(CH_NUL);
		send_transfer(8'h00, 1'b1, 8'hFF);
		send_transfer(8'hFF, 1'b1, 8'h00);
		send_transfer(CH_END, 1'b0, 8'hFF);
		send_transfer(CH_NUL, 1'b1, 8'h77);
		send_transfer(CH_TO_UART, 1'b0, 8'h00);
		send_rx("5");

		// Random traffic: mostly well-formed messages and polls, some noise.
		while (sent < ITEM_TARGET) begin
			if (!paused && sent >= PAUSE_AT) begin
				paused = 1'b1;
				item_ch.valid <= 1'b0;
				do @(negedge clk); while (outstanding != 0);
			end
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					send_rx(CH_TO_CTRL);
					repeat ($urandom_range(0, 6)) send_rx(8'($urandom_range(1, 255)));
					send_rx(CH_END);
				end
				3, 4, 5: begin
					send_rx(CH_TO_UART);
					repeat ($urandom_range(1, 6)) begin
						send_rx(random_hex_char());
						send_rx(random_hex_char());
					end
					send_rx(CH_END);
				end
				6, 7: begin
					poll_burst($urandom_range(0, 5));
				end
				default: begin
					repeat ($urandom_range(1, 8)) send_rx(8'($urandom_range(0, 255)));
				end
			endcase
		end

		// Drain the block and give the verdict.
		item_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/shmr_pkg.sv
src/shmr_if.sv
src/shmr_step.sv
src/spi_slave_hex_message_router_top.sv
verif/shmr_route_check.sv
verif/tb.sv
